// ===== rtl/gpio_pkg.sv =====
// ----------------------------------------------------------------------------
// GPIO package
// Shared constants, codes and word types of the GPIO port with pin interrupts.
// ----------------------------------------------------------------------------
package gpio_pkg;

   localparam int PIN_COUNT = 32;
   localparam int WORD_W    = 32;
   localparam int MODE_W    = 2;
   localparam int CTRL_PINS = WORD_W / MODE_W;

   localparam logic [WORD_W-1:0] PIN_MASK =
      WORD_W'((64'd1 << PIN_COUNT) - 64'd1);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      REG_DATA      = 3'd0,
      REG_DIRECTION = 3'd1,
      REG_MASK      = 3'd2,
      REG_STATUS    = 3'd3,
      REG_CTRL_LOW  = 3'd4,
      REG_CTRL_HIGH = 3'd5,
      REG_EDGE      = 3'd6
   } reg_select_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOW  = 2'd0,
      MODE_HIGH = 2'd1,
      MODE_RISE = 2'd2,
      MODE_FALL = 2'd3
   } mode_type;

   typedef struct packed {
      opcode_type        opcode;
      reg_select_type    reg_select;
      logic [WORD_W-1:0] write_data;
      logic [WORD_W-1:0] pad_levels;
   } req_word_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic [WORD_W-1:0] pad_out;
      logic [WORD_W-1:0] pad_drive_enable;
      logic              irq_line;
   } rsp_word_type;

endpackage

// ===== rtl/gpio_event_det.sv =====
// ----------------------------------------------------------------------------
// GPIO event detector
// Per-pin level and edge detection from the sampled and previous pad levels.
// ----------------------------------------------------------------------------
module gpio_event_det (
   input  logic [gpio_pkg::WORD_W-1:0] pads,
   input  logic [gpio_pkg::WORD_W-1:0] prev_pads,
   input  logic [gpio_pkg::WORD_W-1:0] ctrl_low,
   input  logic [gpio_pkg::WORD_W-1:0] ctrl_high,
   input  logic [gpio_pkg::WORD_W-1:0] both_edge,
   output logic [gpio_pkg::WORD_W-1:0] events
);

   logic [gpio_pkg::WORD_W-1:0] rise;
   logic [gpio_pkg::WORD_W-1:0] fall;
   logic [gpio_pkg::WORD_W-1:0] hit;

   assign rise = pads & ~prev_pads;
   assign fall = prev_pads & ~pads;

   always_comb begin
      gpio_pkg::mode_type mode;
      mode = gpio_pkg::MODE_LOW;
      hit  = '0;
      for (int i = 0; i < gpio_pkg::WORD_W; i++) begin
         if (i < gpio_pkg::CTRL_PINS) begin
            mode = gpio_pkg::mode_type'(ctrl_low[gpio_pkg::MODE_W*i +: gpio_pkg::MODE_W]);
         end else begin
            mode = gpio_pkg::mode_type'(
               ctrl_high[gpio_pkg::MODE_W*(i-gpio_pkg::CTRL_PINS) +: gpio_pkg::MODE_W]);
         end
         if (both_edge[i]) begin
            hit[i] = rise[i] | fall[i];
         end else begin
            case (mode)
               gpio_pkg::MODE_LOW:  hit[i] = ~pads[i];
               gpio_pkg::MODE_HIGH: hit[i] = pads[i];
               gpio_pkg::MODE_RISE: hit[i] = rise[i];
               gpio_pkg::MODE_FALL: hit[i] = fall[i];
               default:             hit[i] = 1'b0;
            endcase
         end
      end
   end

   assign events = hit & gpio_pkg::PIN_MASK;

endmodule

// ===== rtl/gpio_regfile.sv =====
// ----------------------------------------------------------------------------
// GPIO register file
// Holds the port registers, applies one word per execute cycle and forms the
// result word from the state after the update.
// ----------------------------------------------------------------------------
module gpio_regfile (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   exec_en,
   input  gpio_pkg::req_word_type req_word,
   output gpio_pkg::rsp_word_type rsp_word
);

   logic [gpio_pkg::WORD_W-1:0] data_ff,      data_in;
   logic [gpio_pkg::WORD_W-1:0] dir_ff,       dir_in;
   logic [gpio_pkg::WORD_W-1:0] mask_ff,      mask_in;
   logic [gpio_pkg::WORD_W-1:0] status_ff,    status_in;
   logic [gpio_pkg::WORD_W-1:0] ctrl_low_ff,  ctrl_low_in;
   logic [gpio_pkg::WORD_W-1:0] ctrl_high_ff, ctrl_high_in;
   logic [gpio_pkg::WORD_W-1:0] edge_ff,      edge_in;
   logic [gpio_pkg::WORD_W-1:0] prev_ff,      prev_in;
   logic [gpio_pkg::WORD_W-1:0] events;
   logic [gpio_pkg::WORD_W-1:0] read_data;
   logic [gpio_pkg::WORD_W-1:0] wd_pins;

   gpio_event_det u_event_det (
      .pads      (req_word.pad_levels),
      .prev_pads (prev_ff),
      .ctrl_low  (ctrl_low_ff),
      .ctrl_high (ctrl_high_ff),
      .both_edge (edge_ff),
      .events    (events)
   );

   assign wd_pins = req_word.write_data & gpio_pkg::PIN_MASK;

   always_comb begin
      data_in      = data_ff;
      dir_in       = dir_ff;
      mask_in      = mask_ff;
      status_in    = status_ff;
      ctrl_low_in  = ctrl_low_ff;
      ctrl_high_in = ctrl_high_ff;
      edge_in      = edge_ff;
      prev_in      = prev_ff;
      read_data    = '0;
      if (exec_en) begin
         case (req_word.opcode)
            gpio_pkg::OP_TICK: begin
               status_in = status_ff | events;
               prev_in   = req_word.pad_levels;
            end
            gpio_pkg::OP_WRITE: begin
               case (req_word.reg_select)
                  gpio_pkg::REG_DATA:      data_in      = wd_pins;
                  gpio_pkg::REG_DIRECTION: dir_in       = wd_pins;
                  gpio_pkg::REG_MASK:      mask_in      = wd_pins;
                  gpio_pkg::REG_STATUS:    status_in    = status_ff & ~req_word.write_data;
                  gpio_pkg::REG_CTRL_LOW:  ctrl_low_in  = req_word.write_data;
                  gpio_pkg::REG_CTRL_HIGH: ctrl_high_in = req_word.write_data;
                  gpio_pkg::REG_EDGE:      edge_in      = wd_pins;
                  default: ;
               endcase
            end
            gpio_pkg::OP_READ: begin
               case (req_word.reg_select)
                  gpio_pkg::REG_DATA:      read_data = data_ff;
                  gpio_pkg::REG_DIRECTION: read_data = dir_ff;
                  gpio_pkg::REG_MASK:      read_data = mask_ff;
                  gpio_pkg::REG_STATUS:    read_data = status_ff;
                  gpio_pkg::REG_CTRL_LOW:  read_data = ctrl_low_ff;
                  gpio_pkg::REG_CTRL_HIGH: read_data = ctrl_high_ff;
                  gpio_pkg::REG_EDGE:      read_data = edge_ff;
                  default:                 read_data = '0;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_word.read_data        = read_data;
      rsp_word.pad_out          = data_in;
      rsp_word.pad_drive_enable = dir_in;
      rsp_word.irq_line         = |(status_in & mask_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff      <= '0;
         dir_ff       <= '0;
         mask_ff      <= '0;
         status_ff    <= '0;
         ctrl_low_ff  <= '0;
         ctrl_high_ff <= '0;
         edge_ff      <= '0;
         prev_ff      <= '0;
      end else begin
         data_ff      <= data_in;
         dir_ff       <= dir_in;
         mask_ff      <= mask_in;
         status_ff    <= status_in;
         ctrl_low_ff  <= ctrl_low_in;
         ctrl_high_ff <= ctrl_high_in;
         edge_ff      <= edge_in;
         prev_ff      <= prev_in;
      end
   end

   a_read_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (exec_en && req_word.opcode == gpio_pkg::OP_READ) |=>
         ($stable(data_ff) && $stable(status_ff) && $stable(prev_ff)))
      else $error("register read changed port state");

   a_status_sticky: assert property (@(posedge clock) disable iff (reset)
      !(exec_en && req_word.opcode == gpio_pkg::OP_WRITE &&
        req_word.reg_select == gpio_pkg::REG_STATUS) |=>
         ((status_ff & $past(status_ff)) == $past(status_ff)))
      else $error("status bit lost without a status write");

endmodule

// ===== rtl/gpio_port_with_pin_interrupts_core.sv =====
// ----------------------------------------------------------------------------
// GPIO port with pin interrupts
// 32-pin port: data, direction, interrupt mask, write-one-to-clear status,
// per-pin mode words and both-edge select, sampled pads raise status bits.
//
//   channel  direction  ports       content
//   req      in         req_*       opcode, reg_select, write_data, pad_levels
//   rsp      out        rsp_*       read_data, pad_out, pad_drive_enable, irq
//
// One word per cycle sustained while rsp is not stalled; a word is registered
// on entry, executed from the entry register and its result registered.
// Synchronous reset clears port and valid registers, so all pins start as inputs.
// A stalled rsp holds the result; one more word waits in the entry register.
// ----------------------------------------------------------------------------
module gpio_port_with_pin_interrupts_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [2:0]                  req_reg_select,
   input  logic [gpio_pkg::WORD_W-1:0] req_write_data,
   input  logic [gpio_pkg::WORD_W-1:0] req_pad_levels,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gpio_pkg::WORD_W-1:0] rsp_read_data,
   output logic [gpio_pkg::WORD_W-1:0] rsp_pad_out,
   output logic [gpio_pkg::WORD_W-1:0] rsp_pad_drive_enable,
   output logic                        rsp_irq_line
);

   logic                   in_valid_ff, in_valid_in;
   gpio_pkg::req_word_type item_ff,     item_in;
   logic                   out_valid_ff, out_valid_in;
   gpio_pkg::rsp_word_type result_ff,   result_in;
   gpio_pkg::rsp_word_type rsp_word;
   logic                   req_fire;
   logic                   exec_fire;

   assign exec_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || exec_fire;
   assign req_fire  = req_valid && req_ready;

   gpio_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .exec_en  (exec_fire),
      .req_word (item_ff),
      .rsp_word (rsp_word)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_fire) begin
         in_valid_in        = 1'b1;
         item_in.opcode     = gpio_pkg::opcode_type'(req_opcode);
         item_in.reg_select = gpio_pkg::reg_select_type'(req_reg_select);
         item_in.write_data = req_write_data;
         item_in.pad_levels = req_pad_levels;
      end else if (exec_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      result_in    = result_ff;
      if (exec_fire) begin
         out_valid_in = 1'b1;
         result_in    = rsp_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_read_data        = result_ff.read_data;
   assign rsp_pad_out          = result_ff.pad_out;
   assign rsp_pad_drive_enable = result_ff.pad_drive_enable;
   assign rsp_irq_line         = result_ff.irq_line;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("entry stalled with room downstream");

   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> out_valid_ff)
      else $error("executed word produced no result");

   a_entry_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !exec_fire) |=> (in_valid_ff && $stable(item_ff)))
      else $error("waiting word dropped or altered");

endmodule
